// ===== hw/rtl/hpq_pkg.sv =====
// Shared types, codes and defaults for the binary heap priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_WIDTH_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  // register index sits at paddr[2]; byte lanes below it are ignored
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_LAST   = 3'd1,
    RD_PARENT = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_MOVE  = 2'd0,
    WR_CAND  = 2'd1,
    WR_RDATA = 2'd2
  } wr_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_UP_CHECK = 4'd1,
    ST_UP_WAIT  = 4'd2,
    ST_RM_ROOT  = 4'd3,
    ST_RM_LAST  = 4'd4,
    ST_RM_CHECK = 4'd5,
    ST_RM_LEFT  = 4'd6,
    ST_RM_RIGHT = 4'd7,
    ST_RM_CMP   = 4'd8,
    ST_DONE     = 4'd9
  } state_e;

  typedef struct packed {
    logic    take_in;
    logic    clr_res;
    logic    ins_start;
    logic    rm_start;
    logic    clear_cnt;
    logic    cap_root;
    logic    cap_last;
    logic    cap_left;
    logic    cap_right;
    logic    hole_up;
    logic    hole_down;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    load_out;
    status_e status;
  } hpq_cmd_t;

  typedef struct packed {
    logic hole_zero;
    logic full;
    logic empty;
    logic left_ok;
    logic right_ok;
    logic up_prec;
    logic down_prec;
    logic out_free;
  } hpq_sts_t;

endpackage

// ===== hw/rtl/hpq_in_if.sv =====
// Input channel of the heap queue: valid/ready handshake with one operation item.
// Standalone; widths come from the instantiating level.
`timescale 1ns / 1ps

interface hpq_in_if #(
  parameter int KW = 16,
  parameter int DW = 16
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [KW-1:0] key;
  logic [DW-1:0] payload;

  modport source (output valid, output kind, output key, output payload, input ready);
  modport sink   (input valid, input kind, input key, input payload, output ready);
endinterface

// ===== hw/rtl/hpq_out_if.sv =====
// Result channel of the heap queue: valid/ready handshake with one result item.
// Standalone; widths come from the instantiating level.
`timescale 1ns / 1ps

interface hpq_out_if #(
  parameter int KW = 16,
  parameter int DW = 16,
  parameter int CW = 7
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [KW-1:0] out_key;
  logic [DW-1:0] out_payload;
  logic [CW-1:0] entry_count;
  logic          is_empty;
  logic          is_full;

  modport source (output valid, output status, output out_key, output out_payload,
                  output entry_count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue: max- or min-heap of CAPACITY key/payload entries.
// Insert sifts the new entry up and remove sifts the last entry down from the root,
// one level per step; clear and refused items go straight to the result.
// One item in flight; the next is taken the cycle after its result is registered.
// The single-read-port heap RAM sets the per-level cost. Reset empties the heap
// at once (fill count to zero, max-heap order); RAM contents are not cleared.
`timescale 1ns / 1ps

module binary_heap_priority_queue #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = hpq_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = hpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hpq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hpq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hpq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  hpq_in_if.sink                             in_i,
  hpq_out_if.source                          out_o
);

  localparam int CNTW = $clog2(CAPACITY + 1);

  logic              order_mode_q, order_mode_d;
  logic              reg_hit;
  hpq_pkg::hpq_cmd_t cmd;
  hpq_pkg::hpq_sts_t sts;
  logic [CNTW-1:0]   entry_count;

  assign reg_hit = (paddr[2] == hpq_pkg::REG_ORDER_MODE);

  always_comb begin
    order_mode_d = order_mode_q;
    if (psel && penable && pwrite && reg_hit) begin
      order_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
    end else begin
      order_mode_q <= order_mode_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? hpq_pkg::APB_DATA_W'(order_mode_q) : '0;

  hpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .kind_i     (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpq_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .order_mode_i  (order_mode_q),
    .key_i         (in_i.key),
    .payload_i     (in_i.payload),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .out_key_o     (out_o.out_key),
    .out_payload_o (out_o.out_payload),
    .entry_count_o (entry_count),
    .is_empty_o    (out_o.is_empty),
    .is_full_o     (out_o.is_full)
  );

  assign out_o.entry_count = entry_count;

endmodule

// ===== hw/rtl/hpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hpq_dp.sv =====
// Heap queue datapath: fill count, hole and moving-entry registers, heap RAM,
// result register. Depends on hpq_pkg and hpq_ram; driven by hpq_ctrl commands.
`timescale 1ns / 1ps

module hpq_dp #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = hpq_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = hpq_pkg::DATA_WIDTH_DEF,
  localparam int CNTW      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  order_mode_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  input  logic [DATA_WIDTH-1:0] payload_i,
  input  hpq_pkg::hpq_cmd_t     cmd_i,
  output hpq_pkg::hpq_sts_t     sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic [KEY_WIDTH-1:0]  out_key_o,
  output logic [DATA_WIDTH-1:0] out_payload_o,
  output logic [CNTW-1:0]       entry_count_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int EW  = KEY_WIDTH + DATA_WIDTH;
  localparam int CIW = AW + 2;

  logic [CNTW-1:0] count_q, count_d;
  logic [AW-1:0]   hole_q, hole_d;
  logic [EW-1:0]   mk_q, mk_d;
  logic [EW-1:0]   cand_q, cand_d;
  logic [AW-1:0]   cidx_q, cidx_d;
  logic [EW-1:0]   res_q, res_d;

  logic                  out_valid_q;
  hpq_pkg::status_e      ostatus_q;
  logic [EW-1:0]         ores_q;
  logic [CNTW-1:0]       ocnt_q;
  logic                  oempty_q;
  logic                  ofull_q;

  logic [EW-1:0]        rdata;
  logic [KEY_WIDTH-1:0] rkey;
  logic [KEY_WIDTH-1:0] mkey;
  logic [KEY_WIDTH-1:0] ckey;
  logic [AW-1:0]        hole_m1;
  logic [AW-1:0]        parent;
  logic [CIW-1:0]       left;
  logic [CIW-1:0]       right;
  logic [CIW-1:0]       count_ext;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        wdata;
  logic                 out_free;

  // true when b belongs nearer the root than a
  function automatic logic precedes(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 mode);
    precedes = mode ? (a > b) : (a < b);
  endfunction

  assign rkey      = rdata[EW-1:DATA_WIDTH];
  assign mkey      = mk_q[EW-1:DATA_WIDTH];
  assign ckey      = cand_q[EW-1:DATA_WIDTH];
  assign hole_m1   = hole_q - AW'(1);
  assign parent    = hole_m1 >> 1;
  assign left      = {1'b0, hole_q, 1'b1};
  assign right     = left + CIW'(1);
  assign count_ext = CIW'(count_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      hpq_pkg::RD_ROOT:   raddr = '0;
      hpq_pkg::RD_LAST:   raddr = count_q[AW-1:0];
      hpq_pkg::RD_PARENT: raddr = parent;
      hpq_pkg::RD_LEFT:   raddr = left[AW-1:0];
      hpq_pkg::RD_RIGHT:  raddr = right[AW-1:0];
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      hpq_pkg::WR_MOVE:  wdata = mk_q;
      hpq_pkg::WR_CAND:  wdata = cand_q;
      hpq_pkg::WR_RDATA: wdata = rdata;
      default:           wdata = mk_q;
    endcase
  end

  hpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (hole_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    hole_d  = hole_q;
    mk_d    = mk_q;
    cand_d  = cand_q;
    cidx_d  = cidx_q;
    res_d   = res_q;
    if (cmd_i.take_in) begin
      mk_d = {key_i, payload_i};
    end
    if (cmd_i.clr_res) begin
      res_d = '0;
    end
    if (cmd_i.ins_start) begin
      hole_d  = count_q[AW-1:0];
      count_d = count_q + CNTW'(1);
    end
    if (cmd_i.rm_start) begin
      count_d = count_q - CNTW'(1);
    end
    if (cmd_i.clear_cnt) begin
      count_d = '0;
    end
    if (cmd_i.cap_root) begin
      res_d = rdata;
    end
    if (cmd_i.cap_last) begin
      mk_d   = rdata;
      hole_d = '0;
    end
    if (cmd_i.cap_left) begin
      cand_d = rdata;
      cidx_d = left[AW-1:0];
    end
    // take the right child only when it strictly precedes the left one
    if (cmd_i.cap_right && precedes(ckey, rkey, order_mode_i)) begin
      cand_d = rdata;
      cidx_d = right[AW-1:0];
    end
    if (cmd_i.hole_up) begin
      hole_d = parent;
    end
    if (cmd_i.hole_down) begin
      hole_d = cidx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    mk_q   <= mk_d;
    cand_q <= cand_d;
    cidx_q <= cidx_d;
    res_q  <= res_d;
    if (cmd_i.load_out) begin
      ostatus_q <= cmd_i.status;
      ores_q    <= res_q;
      ocnt_q    <= count_q;
      oempty_q  <= (count_q == '0);
      ofull_q   <= (count_q == CNTW'(CAPACITY));
    end
  end

  assign sts_o.hole_zero = (hole_q == '0);
  assign sts_o.full      = (count_q == CNTW'(CAPACITY));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.left_ok   = (left < count_ext);
  assign sts_o.right_ok  = (right < count_ext);
  assign sts_o.up_prec   = precedes(rkey, mkey, order_mode_i);
  assign sts_o.down_prec = precedes(mkey, ckey, order_mode_i);
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_o      = ostatus_q;
  assign out_key_o     = ores_q[EW-1:DATA_WIDTH];
  assign out_payload_o = ores_q[DATA_WIDTH-1:0];
  assign entry_count_o = ocnt_q;
  assign is_empty_o    = oempty_q;
  assign is_full_o     = ofull_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("fill count above capacity");

  a_write_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (CNTW'(hole_q) < count_q || count_q == '0))
    else $error("heap write outside occupied slots");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("result loaded over an untaken item");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_start |=> count_q == $past(count_q) + CNTW'(1))
    else $error("insert did not advance the fill count");
`endif

endmodule

// ===== hw/rtl/hpq_ctrl.sv =====
// Heap queue controller: state machine that sequences sift-up and sift-down
// steps over the datapath. Depends on hpq_pkg.
`timescale 1ns / 1ps

module hpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        kind_i,
  output logic              in_ready_o,
  input  hpq_pkg::hpq_sts_t sts_i,
  output hpq_pkg::hpq_cmd_t cmd_o
);

  hpq_pkg::state_e  state_q, state_d;
  hpq_pkg::status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hpq_pkg::ST_IDLE;
      status_q <= hpq_pkg::STATUS_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.rd_sel = hpq_pkg::RD_ROOT;
    cmd_o.wr_sel = hpq_pkg::WR_MOVE;
    cmd_o.status = status_q;
    case (state_q)
      hpq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          cmd_o.clr_res = 1'b1;
          status_d      = hpq_pkg::STATUS_DONE;
          state_d       = hpq_pkg::ST_DONE;
          case (hpq_pkg::kind_e'(kind_i))
            hpq_pkg::KIND_INSERT: begin
              if (sts_i.full) begin
                status_d = hpq_pkg::STATUS_FULL;
              end else begin
                cmd_o.ins_start = 1'b1;
                state_d         = hpq_pkg::ST_UP_CHECK;
              end
            end
            hpq_pkg::KIND_REMOVE: begin
              if (sts_i.empty) begin
                status_d = hpq_pkg::STATUS_EMPTY;
              end else begin
                cmd_o.rm_start = 1'b1;
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_sel   = hpq_pkg::RD_ROOT;
                state_d        = hpq_pkg::ST_RM_ROOT;
              end
            end
            hpq_pkg::KIND_CLEAR: begin
              cmd_o.clear_cnt = 1'b1;
            end
            default: begin
              // unused operation: report count only
            end
          endcase
        end
      end
      hpq_pkg::ST_UP_CHECK: begin
        if (sts_i.hole_zero) begin
          cmd_o.wr_en = 1'b1;
          state_d     = hpq_pkg::ST_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = hpq_pkg::RD_PARENT;
          state_d      = hpq_pkg::ST_UP_WAIT;
        end
      end
      hpq_pkg::ST_UP_WAIT: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.up_prec) begin
          // move the parent down into the hole and climb
          cmd_o.wr_sel  = hpq_pkg::WR_RDATA;
          cmd_o.hole_up = 1'b1;
          state_d       = hpq_pkg::ST_UP_CHECK;
        end else begin
          state_d = hpq_pkg::ST_DONE;
        end
      end
      hpq_pkg::ST_RM_ROOT: begin
        cmd_o.cap_root = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = hpq_pkg::RD_LAST;
        state_d        = hpq_pkg::ST_RM_LAST;
      end
      hpq_pkg::ST_RM_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d        = hpq_pkg::ST_RM_CHECK;
      end
      hpq_pkg::ST_RM_CHECK: begin
        if (sts_i.left_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = hpq_pkg::RD_LEFT;
          state_d      = hpq_pkg::ST_RM_LEFT;
        end else begin
          cmd_o.wr_en = 1'b1;
          state_d     = hpq_pkg::ST_DONE;
        end
      end
      hpq_pkg::ST_RM_LEFT: begin
        cmd_o.cap_left = 1'b1;
        if (sts_i.right_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = hpq_pkg::RD_RIGHT;
          state_d      = hpq_pkg::ST_RM_RIGHT;
        end else begin
          state_d = hpq_pkg::ST_RM_CMP;
        end
      end
      hpq_pkg::ST_RM_RIGHT: begin
        cmd_o.cap_right = 1'b1;
        state_d         = hpq_pkg::ST_RM_CMP;
      end
      hpq_pkg::ST_RM_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.down_prec) begin
          // pull the chosen child up into the hole and descend
          cmd_o.wr_sel    = hpq_pkg::WR_CAND;
          cmd_o.hole_down = 1'b1;
          state_d         = hpq_pkg::ST_RM_CHECK;
        end else begin
          state_d = hpq_pkg::ST_DONE;
        end
      end
      hpq_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = hpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hpq_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(cmd_o.wr_en || cmd_o.rd_en))
    else $error("heap access in the result cycle");

  a_write_move_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_en && cmd_o.wr_sel == hpq_pkg::WR_MOVE) |=> state_q == hpq_pkg::ST_DONE)
    else $error("moving entry placed before the sift finished");
`endif

endmodule
